// ===== hw/rtl/tccw_pkg.sv =====
// Package for the text console character writer.
// Holds screen geometry, character codes, item classes and the structs passed
// between the front and back parts. Depends on nothing.
package tccw_pkg;

  localparam int ROWS    = 25;
  localparam int COLUMNS = 80;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam logic [7:0]  ATTR_RESET  = 8'h0F;
  localparam logic [15:0] BLANK_RESET = 16'h0F20;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SIX      = 8'h36;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] CLS_READ      = 2'd0;
  localparam logic [1:0] CLS_NEWLINE   = 2'd1;
  localparam logic [1:0] CLS_BACKSPACE = 2'd2;
  localparam logic [1:0] CLS_PRINT     = 2'd3;

  typedef struct packed {
    logic [1:0] cls;
    logic [7:0] chr;
    logic [4:0] row;
    logic [6:0] col;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

// ===== hw/rtl/text_console_char_writer.sv =====
// Top level of the text console character writer.
// Instantiates tccw_front, tccw_back; holds the attribute register; uses tccw_pkg.
//
// A command transaction is accepted at a clock edge where start is high and
// busy is low. operation selects a put of character or a read of the cell at
// cell_row, cell_col. Put results come out one per cycle, each shown for exactly
// one cycle with result_valid high; last marks the final result of a command.
// A put gives one serial byte (three for backspace, two for newline), a read
// gives one cell. The front holds up to two commands in a queue, so start may
// be given while the back is still working.
// A command put in an empty queue is at its head in the cycle after acceptance;
// the back takes it in its idle state, then shows a read's result from its read
// state or a put's results from its emit state, one result per cycle. A put that
// scrolls then blanks the new bottom row in a sweep state, as the screen memory
// has a single write port.
// After reset the screen memory is cleared cell by cell, during which busy is
// high; configuration writes are still taken.
// The receiver cannot stall results: each result must be taken as shown.
// text_attribute lies at APB address 0 and resets to 0x0F.
module text_console_char_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [7:0]  character,
  input  logic [4:0]  cell_row,
  input  logic [6:0]  cell_col,
  output logic        result_valid,
  output logic        result_kind,
  output logic [7:0]  serial_byte,
  output logic [15:0] cell_data,
  output logic        query_seen,
  output logic [4:0]  row_now,
  output logic [6:0]  col_now,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tccw_pkg::*;

  logic       [7:0] text_attribute;
  head_t            head;
  back_stat_t       stat;

  // The attribute register is written on the access phase of an APB write.
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {24'h000000, text_attribute} : 32'h00000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 1'b0) begin
      text_attribute <= pwdata[7:0];
    end
  end

  tccw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .character (character),
    .cell_row  (cell_row),
    .cell_col  (cell_col),
    .stat      (stat),
    .busy      (busy),
    .head      (head)
  );

  tccw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .text_attribute (text_attribute),
    .head           (head),
    .stat           (stat),
    .result_valid   (result_valid),
    .result_kind    (result_kind),
    .serial_byte    (serial_byte),
    .cell_data      (cell_data),
    .query_seen     (query_seen),
    .row_now        (row_now),
    .col_now        (col_now),
    .last           (last)
  );

endmodule

// ===== hw/rtl/tccw_front.sv =====
// Front part of the text console character writer: accepts commands,
// classifies them and holds them in a two-entry queue. Depends on tccw_pkg.
module tccw_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                operation,
  input  logic [7:0]          character,
  input  logic [4:0]          cell_row,
  input  logic [6:0]          cell_col,
  input  tccw_pkg::back_stat_t stat,
  output logic                busy,
  output tccw_pkg::head_t     head
);
  import tccw_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  entry_t     incoming;

  assign busy = (count == 2'd2) || stat.clearing;
  assign push = start && !busy;
  assign pop  = stat.pop && (count != 2'd0);

  always_comb begin
    incoming.chr = character;
    incoming.row = cell_row;
    incoming.col = cell_col;
    if (operation == OP_READ) begin
      incoming.cls = CLS_READ;
    end else if (character == CH_LF) begin
      incoming.cls = CLS_NEWLINE;
    end else if (character == CH_BS) begin
      incoming.cls = CLS_BACKSPACE;
    end else begin
      incoming.cls = CLS_PRINT;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.entry = slots[rd_ptr];

endmodule

// ===== hw/rtl/tccw_back.sv =====
// Back part of the text console character writer: screen memory, cursor,
// escape tracker, scroll sweep and result sequencing. Depends on tccw_pkg.
module tccw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           text_attribute,
  input  tccw_pkg::head_t      head,
  output tccw_pkg::back_stat_t stat,
  output logic                 result_valid,
  output logic                 result_kind,
  output logic [7:0]           serial_byte,
  output logic [15:0]          cell_data,
  output logic                 query_seen,
  output logic [4:0]           row_now,
  output logic [6:0]           col_now,
  output logic                 last
);
  import tccw_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata;

  logic [2:0]        state, state_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  top, top_next;
  logic [1:0]        esc, esc_next;
  logic              q, q_next;
  logic [1:0]        cls, cls_next;
  logic [7:0]        chr, chr_next;
  logic [1:0]        idx, idx_next;
  logic              in_range, in_range_next;
  logic              sweep_pend, sweep_pend_next;
  logic [ROW_W-1:0]  sweep_row, sweep_row_next;
  logic [COL_W-1:0]  sweep_col, sweep_col_next;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata;
  logic [1:0]        emit_count;
  logic [15:0]       blank;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] t,
                                                input logic [ROW_W-1:0] r);
    logic [ROW_W:0] s;
    s = {1'b0, t} + {1'b0, r};
    if (s >= (ROW_W+1)'(ROWS)) begin
      s = s - (ROW_W+1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] p,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(p * COLUMNS + c);
  endfunction

  assign blank = {text_attribute, CH_SPACE};

  always_comb begin
    unique case (cls)
      CLS_NEWLINE:   emit_count = 2'd2;
      CLS_BACKSPACE: emit_count = 2'd3;
      default:       emit_count = 2'd1;
    endcase
  end

  always_comb begin
    logic hit;
    logic adv;
    state_next      = state;
    clr_addr_next   = clr_addr;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    top_next        = top;
    esc_next        = esc;
    q_next          = q;
    cls_next        = cls;
    chr_next        = chr;
    idx_next        = idx;
    in_range_next   = in_range;
    sweep_pend_next = sweep_pend;
    sweep_row_next  = sweep_row;
    sweep_col_next  = sweep_col;
    we              = 1'b0;
    waddr           = cell_addr(phys_row(top, cur_row), cur_col);
    wdata           = blank;
    raddr           = cell_addr(phys_row(top, ROW_W'(head.entry.row)),
                                COL_W'(head.entry.col));
    stat.pop        = 1'b0;
    stat.clearing   = (state == S_CLEAR);
    hit             = 1'b0;
    adv             = 1'b0;

    unique case (state)
      S_CLEAR: begin
        we            = 1'b1;
        waddr         = clr_addr;
        wdata         = BLANK_RESET;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          stat.pop = 1'b1;
          cls_next = head.entry.cls;
          chr_next = head.entry.chr;
          idx_next = 2'd0;
          if (head.entry.cls == CLS_READ) begin
            in_range_next = (head.entry.row < 5'(ROWS)) &&
                            (head.entry.col < 7'(COLUMNS));
            state_next    = S_READ;
          end else begin
            priority if (esc == 2'd1 && head.entry.chr == CH_LBRACKET) begin
              esc_next = 2'd2;
            end else if (esc == 2'd2 && head.entry.chr == CH_SIX) begin
              esc_next = 2'd3;
            end else if (esc == 2'd3 && head.entry.chr == CH_N) begin
              esc_next = 2'd0;
              hit      = 1'b1;
            end else begin
              esc_next = (head.entry.chr == CH_ESC) ? 2'd1 : 2'd0;
            end
            q_next     = hit;
            state_next = S_EMIT;
            unique case (head.entry.cls)
              CLS_NEWLINE: begin
                adv = 1'b1;
              end
              CLS_BACKSPACE: begin
                if (cur_col != '0) begin
                  cur_col_next = cur_col - 1'b1;
                  we           = 1'b1;
                  waddr        = cell_addr(phys_row(top, cur_row), cur_col - 1'b1);
                end
              end
              default: begin
                we    = 1'b1;
                wdata = {text_attribute, head.entry.chr};
                if (cur_col == COL_W'(COLUMNS - 1)) begin
                  adv = 1'b1;
                end else begin
                  cur_col_next = cur_col + 1'b1;
                end
              end
            endcase
            if (adv) begin
              cur_col_next = '0;
              if (cur_row == ROW_W'(ROWS - 1)) begin
                // Scroll: the old top row becomes the new, blank bottom row.
                sweep_pend_next = 1'b1;
                sweep_row_next  = top;
                sweep_col_next  = '0;
                top_next        = (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;
              end else begin
                cur_row_next = cur_row + 1'b1;
              end
            end
          end
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      S_EMIT: begin
        idx_next = idx + 1'b1;
        if (idx == emit_count - 2'd1) begin
          state_next = sweep_pend ? S_SWEEP : S_IDLE;
        end
      end
      S_SWEEP: begin
        we             = 1'b1;
        waddr          = cell_addr(sweep_row, sweep_col);
        sweep_col_next = sweep_col + 1'b1;
        if (sweep_col == COL_W'(COLUMNS - 1)) begin
          sweep_pend_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      top        <= '0;
      esc        <= 2'd0;
      sweep_pend <= 1'b0;
      idx        <= 2'd0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      cur_row    <= cur_row_next;
      cur_col    <= cur_col_next;
      top        <= top_next;
      esc        <= esc_next;
      sweep_pend <= sweep_pend_next;
      idx        <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    q         <= q_next;
    cls       <= cls_next;
    chr       <= chr_next;
    in_range  <= in_range_next;
    sweep_row <= sweep_row_next;
    sweep_col <= sweep_col_next;
  end

  always_comb begin
    serial_byte = 8'h00;
    if (state == S_EMIT) begin
      unique case (cls)
        CLS_NEWLINE:   serial_byte = (idx == 2'd0) ? CH_CR : CH_LF;
        CLS_BACKSPACE: serial_byte = (idx == 2'd1) ? CH_SPACE : CH_BS;
        default:       serial_byte = chr;
      endcase
    end
  end

  assign result_valid = (state == S_EMIT) || (state == S_READ);
  assign result_kind  = (state == S_READ);
  assign cell_data    = (state == S_READ && in_range) ? rdata : 16'h0000;
  assign query_seen   = (state == S_EMIT) && q;
  assign row_now      = 5'(cur_row);
  assign col_now      = 7'(cur_col);
  assign last         = (state == S_READ) ||
                        ((state == S_EMIT) && (idx == emit_count - 2'd1));

endmodule

// ===== tb/text_console_char_writer_tb.sv =====
// Testbench for the text console character writer: drives put and read commands
// and APB attribute writes, and checks every result against a built-in screen predictor.
// Depends on tccw_pkg and text_console_char_writer.
module text_console_char_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  // Escape tracker states for the cursor-position query ESC [ 6 n.
  localparam logic [1:0] ESC_IDLE  = 2'd0;
  localparam logic [1:0] ESC_SEEN  = 2'd1;
  localparam logic [1:0] ESC_BRACK = 2'd2;
  localparam logic [1:0] ESC_SIX   = 2'd3;

  localparam logic ADDR_ATTR = 1'b0;
  localparam logic KIND_SERIAL = 1'b0;
  localparam logic KIND_CELL   = 1'b1;

  // Settle time before an attribute write: covers a put that scrolls.
  localparam int SETTLE_CYCLES = 2 * COLUMNS + 40;

  typedef struct {
    logic        kind;
    logic [7:0]  ser;
    logic [15:0] cdata;
    logic        query;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        last;
  } console_result_t;

  // The scoreboard keeps its own copy of the screen, cursor, escape tracker and
  // attribute, and queues the results that each accepted transaction should give.
  class console_scoreboard;
    logic [15:0]     screen[CELLS];
    int              cur_row;
    int              cur_col;
    logic [1:0]      esc_state;
    logic [7:0]      attr;
    console_result_t pending[$];
    int              errors;
    int              scrolls;
    int              queries;
    int              reads;
    int              wraps;

    function new();
      attr = ATTR_RESET;
      foreach (screen[i]) screen[i] = BLANK_RESET;
      cur_row = 0;
      cur_col = 0;
      esc_state = ESC_IDLE;
    endfunction

    function logic [15:0] blank();
      return {attr, CH_SPACE};
    endfunction

    function bit step_escape(logic [7:0] ch);
      bit hit;
      hit = 0;
      if (esc_state == ESC_SEEN && ch == CH_LBRACKET) esc_state = ESC_BRACK;
      else if (esc_state == ESC_BRACK && ch == CH_SIX) esc_state = ESC_SIX;
      else if (esc_state == ESC_SIX && ch == CH_N) begin
        esc_state = ESC_IDLE;
        hit = 1;
      end else esc_state = (ch == CH_ESC) ? ESC_SEEN : ESC_IDLE;
      return hit;
    endfunction

    // Moves the cursor to the next line; past the bottom the screen rolls up.
    function void line_feed();
      cur_col = 0;
      cur_row++;
      if (cur_row < ROWS) return;
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      cur_row = ROWS - 1;
      for (int c = 0; c < COLUMNS; c++) screen[cur_row * COLUMNS + c] = blank();
      scrolls++;
    endfunction

    function void push_result(logic kind, logic [7:0] ser, logic [15:0] cdata, logic q,
                              logic last);
      console_result_t r;
      r.kind = kind;
      r.ser = ser;
      r.cdata = cdata;
      r.query = q;
      r.row = cur_row[4:0];
      r.col = cur_col[6:0];
      r.last = last;
      pending.push_back(r);
    endfunction

    function void note(logic op, logic [7:0] ch, logic [4:0] row, logic [6:0] col);
      bit q;
      logic [15:0] cdata;
      if (op == OP_READ) begin
        cdata = 16'h0000;
        if (row < ROWS && col < COLUMNS) cdata = screen[row * COLUMNS + col];
        reads++;
        push_result(KIND_CELL, 8'h00, cdata, 1'b0, 1'b1);
        return;
      end
      q = step_escape(ch);
      if (q) queries++;
      if (ch == CH_LF) begin
        line_feed();
        push_result(KIND_SERIAL, CH_CR, 16'h0000, q, 1'b0);
        push_result(KIND_SERIAL, CH_LF, 16'h0000, q, 1'b1);
      end else if (ch == CH_BS) begin
        // At column zero the serial bytes still go out but the screen stays.
        if (cur_col != 0) begin
          cur_col--;
          screen[cur_row * COLUMNS + cur_col] = blank();
        end
        push_result(KIND_SERIAL, CH_BS, 16'h0000, q, 1'b0);
        push_result(KIND_SERIAL, CH_SPACE, 16'h0000, q, 1'b0);
        push_result(KIND_SERIAL, CH_BS, 16'h0000, q, 1'b1);
      end else begin
        screen[cur_row * COLUMNS + cur_col] = {attr, ch};
        cur_col++;
        if (cur_col >= COLUMNS) begin
          wraps++;
          line_feed();
        end
        push_result(KIND_SERIAL, ch, 16'h0000, q, 1'b1);
      end
    endfunction

    task report(string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      errors++;
    endtask

    task check(console_result_t got);
      console_result_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result kind=%0b ser=%h cell=%h", got.kind, got.ser,
                         got.cdata));
        return;
      end
      w = pending.pop_front();
      if (got.kind !== w.kind || got.ser !== w.ser || got.cdata !== w.cdata ||
          got.query !== w.query || got.row !== w.row || got.col !== w.col ||
          got.last !== w.last)
        report($sformatf("got k%0b s%h c%h q%0b r%0d c%0d l%0b, want k%0b s%h c%h q%0b r%0d c%0d l%0b",
                         got.kind, got.ser, got.cdata, got.query, got.row, got.col, got.last,
                         w.kind, w.ser, w.cdata, w.query, w.row, w.col, w.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        operation = OP_PUT;
  logic [7:0]  character = 8'h00;
  logic [4:0]  cell_row = 5'd0;
  logic [6:0]  cell_col = 7'd0;
  logic        result_valid;
  logic        result_kind;
  logic [7:0]  serial_byte;
  logic [15:0] cell_data;
  logic        query_seen;
  logic [4:0]  row_now;
  logic [6:0]  col_now;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic        paddr = ADDR_ATTR;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  console_scoreboard sb = new();
  int sent;
  int attr_writes;
  bit quiet;   // set for the final stretch, where no idle gaps are inserted

  always #5 clk = ~clk;

  text_console_char_writer DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .character(character), .cell_row(cell_row), .cell_col(cell_col),
    .result_valid(result_valid), .result_kind(result_kind), .serial_byte(serial_byte),
    .cell_data(cell_data), .query_seen(query_seen), .row_now(row_now), .col_now(col_now),
    .last(last), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Every result is shown for one cycle only, so it is captured at the edge
  // that ends that cycle.
  always @(posedge clk) begin
    console_result_t got;
    if (!rst && result_valid === 1'b1) begin
      got.kind = result_kind;
      got.ser = serial_byte;
      got.cdata = cell_data;
      got.query = query_seen;
      got.row = row_now;
      got.col = col_now;
      got.last = last;
      sb.check(got);
    end
  end

  // Presents one command transaction and holds it until an edge sees busy low.
  // start stays high afterwards, so a back-to-back command need not raise it again.
  task send_cmd(logic op, logic [7:0] ch, logic [4:0] row, logic [6:0] col);
    @(negedge clk);
    start = 1'b1;
    operation = op;
    character = ch;
    cell_row = row;
    cell_col = col;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note(op, ch, row, col);
    sent++;
  endtask

  task put_char(logic [7:0] ch);
    send_cmd(OP_PUT, ch, 5'($urandom), 7'($urandom));
  endtask

  task read_cell(logic [4:0] row, logic [6:0] col);
    send_cmd(OP_READ, 8'($urandom), row, col);
  endtask

  // Random idle burst on the command side, skipped now and then and in the end phase.
  task maybe_idle();
    if (quiet || $urandom_range(0, 2) == 0) return;
    @(negedge clk);
    start = 1'b0;
    repeat ($urandom_range(1, 12) - 1) @(negedge clk);
  endtask

  // Lets every queued result come out, then waits long enough for a scroll
  // that produces no further result to finish before the attribute changes.
  task drain();
    int guard;
    @(negedge clk);
    start = 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_attr(logic [7:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_ATTR;
    pwdata = {$urandom} & 32'hFFFF_FF00 | 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (pready === 1'b1) sb.attr = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    attr_writes++;
  endtask

  task send_query();
    put_char(CH_ESC);
    maybe_idle();
    put_char(CH_LBRACKET);
    maybe_idle();
    put_char(CH_SIX);
    maybe_idle();
    put_char(CH_N);
  endtask

  // One random item. Most are plain puts; newlines, backspaces, escape
  // sequences (whole and broken) and reads, some outside the screen, are mixed in.
  task random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      if ($urandom_range(0, 4) == 0) read_cell(5'($urandom), 7'($urandom));
      else read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
    end else if (pick < 26) put_char(CH_LF);
    else if (pick < 34) put_char(CH_BS);
    else if (pick < 38) send_query();
    else if (pick < 42) begin
      put_char(CH_ESC);
      maybe_idle();
      put_char($urandom_range(0, 1) ? CH_LBRACKET : CH_ESC);
      maybe_idle();
      put_char(8'($urandom));
    end else if (pick < 70) put_char(8'($urandom_range(8'h21, 8'h7E)));
    else put_char(8'($urandom));
  endtask

  initial begin
    logic [7:0] attr_set[4];
    int guard;
    sent = 0;
    attr_writes = 0;
    quiet = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The register is taken even while the screen is still being cleared.
    write_attr(8'h3C);

    // Directed part: field extremes, escape handling, backspace at column
    // zero, and reads inside and outside the screen.
    put_char(CH_BS);
    read_cell(5'd0, 7'd0);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CH_BS);
    read_cell(5'd0, 7'd1);
    send_query();
    put_char(CH_ESC);
    send_query();
    put_char(CH_ESC);
    put_char(CH_LBRACKET);
    put_char(CH_LF);
    put_char(CH_SIX);
    read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
    read_cell(5'd31, 7'd127);
    read_cell(5'd0, 7'(COLUMNS));
    read_cell(5'(ROWS), 7'd0);
    read_cell(5'd0, 7'd0);
    drain();

    // Random part in several attribute settings, extremes included.
    attr_set[0] = 8'h00;
    attr_set[1] = 8'hFF;
    attr_set[2] = 8'($urandom);
    attr_set[3] = ATTR_RESET;
    for (int ph = 0; ph < 4; ph++) begin
      write_attr(attr_set[ph]);
      if (ph == 3) quiet = 1;
      for (int i = 0; i < 6; i++) begin
        random_item();
        maybe_idle();
      end
      // One phase walks the cursor down through a roll-up and then types one
      // long line on the bottom row, so the column wrap scrolls the screen too.
      if (ph == 1) begin
        repeat (ROWS) put_char(CH_LF);
        repeat (COLUMNS + 1) begin
          put_char(8'($urandom_range(8'h21, 8'h7E)));
          maybe_idle();
        end
        read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
      end
      drain();
    end

    guard = 0;
    while (sb.pending.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));

    $display("Covered %0d commands, %0d reads, %0d attribute writes.", sent, sb.reads,
             attr_writes);
    $display("Saw %0d scrolls, %0d line wraps and %0d cursor queries.", sb.scrolls,
             sb.wraps, sb.queries);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, scroll cost and clearing included.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_front.sv
hw/rtl/tccw_back.sv
hw/rtl/text_console_char_writer.sv
tb/text_console_char_writer_tb.sv
